// ===== rtl/urqs_pkg.sv =====
// ----------------------------------------------------------------------------
// urqs_pkg
// Shared types, constants and the restoring-division step used by the
// uniform mod-q rejection sampler.
// ----------------------------------------------------------------------------
package urqs_pkg;

    localparam int WORD_W         = 64;
    localparam int MOD_W          = 61;
    localparam int MOD_COUNT      = 4;
    localparam int SEL_W          = 2;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 64;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = WORD_W / BITS_PER_STAGE;
    localparam int OUT_DATA_W     = 64;

    localparam logic [MOD_W-1:0]  MOD_RESET = MOD_W'(2);
    localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};

    // Item moving through the division pipeline
    typedef struct packed {
        logic [WORD_W-1:0] word;   // original random word
        logic [WORD_W-1:0] shift;  // dividend bits not yet consumed
        logic [MOD_W-1:0]  rem;    // partial remainder of word mod q
        logic [MOD_W-1:0]  rmax;   // partial remainder of (2^64-1) mod q
        logic [MOD_W-1:0]  q;      // effective modulus
        logic              ok;     // selector names a configured modulus
    } t_item;

    // Item after the limit is formed
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] limit;
        logic [MOD_W-1:0]  rem;
        logic              ok;
    } t_fin;

    typedef logic [MOD_W-1:0] t_mod_array [MOD_COUNT];

    // Consume BITS_PER_STAGE dividend bits for both remainder chains
    function automatic t_item div_steps(t_item d);
        t_item       r;
        logic [MOD_W:0] t;
        logic [MOD_W:0] u;
        r = d;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            t = {r.rem, r.shift[WORD_W-1]};
            if (t >= {1'b0, r.q}) begin
                t = t - {1'b0, r.q};
            end
            r.rem = t[MOD_W-1:0];
            u = {r.rmax, 1'b1};
            if (u >= {1'b0, r.q}) begin
                u = u - {1'b0, r.q};
            end
            r.rmax  = u[MOD_W-1:0];
            r.shift = {r.shift[WORD_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/urqs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// urqs_cfg_regs
// Modulus register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module urqs_cfg_regs
    import urqs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_mod_array            o_moduli
);

    t_mod_array r_mod;

    assign o_cfg_ready = 1'b1;
    assign o_moduli    = r_mod;

    // Store the low modulus bits; drop writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOD_COUNT; i++) begin
                r_mod[i] <= MOD_RESET;
            end
        end else if (i_cfg_valid) begin
            for (int i = 0; i < MOD_COUNT; i++) begin
                if (i_cfg_index == CFG_IDX_W'(i)) begin
                    r_mod[i] <= i_cfg_data[MOD_W-1:0];
                end
            end
        end
    end

endmodule

// ===== rtl/urqs_div_stage.sv =====
// ----------------------------------------------------------------------------
// urqs_div_stage
// One register stage of the restoring division pipeline.
// ----------------------------------------------------------------------------
module urqs_div_stage
    import urqs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_data
);

    logic  r_valid;
    t_item r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Advance the stage whenever the slot is free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= div_steps(i_data);
        end
    end

endmodule

// ===== rtl/uniform_mod_q_rejection_sampler_top.sv =====
// ----------------------------------------------------------------------------
// uniform_mod_q_rejection_sampler_top
// Reduces 64-bit random words modulo a selected modulus, rejecting words at
// or above the limit (2^64-1) - ((2^64-1) mod q) - 1.
//
//   channel  direction  contents
//   s_axis   in         tdata: random_word[63:0]; tuser: modulus_select[1:0]
//   m_axis   out        tdata: residue[60:0], zero pad; tuser: accepted
//   cfg      in         index: register 0..3; data: modulus in low 61 bits
//
// One word per cycle sustained unless the output stalls; 32 division stages of
// two remainder bits each, one stage to form the limit, one output register.
// Reset (synchronous, active low) empties the pipeline and sets every
// modulus to 2. A stalled output holds; free stages upstream keep filling.
// ----------------------------------------------------------------------------
module uniform_mod_q_rejection_sampler_top
    import urqs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [WORD_W-1:0]     i_s_axis_tdata,   // random_word
    input  logic [SEL_W-1:0]      i_s_axis_tuser,   // modulus_select
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // residue, zero pad above
    output logic                  o_m_axis_tuser,   // accepted
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_mod_array        moduli;
    t_item             in_item;
    logic [MOD_W-1:0]  q_sel;
    logic              sel_ok;
    logic              v     [DIV_STAGES+1];
    logic              rdy   [DIV_STAGES+1];
    t_item             d     [DIV_STAGES+1];
    logic              r_fin_valid;
    t_fin              r_fin;
    logic              fin_ready;
    logic              r_out_valid;
    logic [MOD_W-1:0]  r_residue;
    logic              r_accepted;
    logic              out_ready;
    logic              accept_now;

    urqs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_moduli    (moduli)
    );

    // Select the modulus; a zero modulus acts as one
    always_comb begin
        sel_ok = ({1'b0, i_s_axis_tuser} < (SEL_W+1)'(MOD_COUNT));
        q_sel  = moduli[i_s_axis_tuser];
        if (q_sel == '0) begin
            q_sel = MOD_W'(1);
        end
        in_item.word  = i_s_axis_tdata;
        in_item.shift = i_s_axis_tdata;
        in_item.rem   = '0;
        in_item.rmax  = '0;
        in_item.q     = q_sel;
        in_item.ok    = sel_ok;
    end

    assign v[0]            = i_s_axis_tvalid;
    assign d[0]            = in_item;
    assign o_s_axis_tready = rdy[0];

    // Division pipeline
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        urqs_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[g]),
            .o_ready (rdy[g]),
            .i_data  (d[g]),
            .o_valid (v[g+1]),
            .i_ready (rdy[g+1]),
            .o_data  (d[g+1])
        );
    end

    assign rdy[DIV_STAGES] = fin_ready;
    assign fin_ready       = !r_fin_valid || out_ready;
    assign out_ready       = !r_out_valid || i_m_axis_tready;

    // Form the rejection limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (fin_ready) begin
            r_fin_valid <= v[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_ready && v[DIV_STAGES]) begin
            r_fin.word  <= d[DIV_STAGES].word;
            r_fin.rem   <= d[DIV_STAGES].rem;
            r_fin.ok    <= d[DIV_STAGES].ok;
            r_fin.limit <= WORD_ONES - {{(WORD_W-MOD_W){1'b0}}, d[DIV_STAGES].rmax}
                           - WORD_W'(1);
        end
    end

    // Compare against the limit and hold the result for the consumer
    assign accept_now = r_fin.ok && (r_fin.word < r_fin.limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_fin_valid) begin
            r_accepted <= accept_now;
            r_residue  <= accept_now ? r_fin.rem : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-MOD_W){1'b0}}, r_residue};
    assign o_m_axis_tuser  = r_accepted;

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("rejected word carries a nonzero residue");

    a_in_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> v[1])
        else $error("accepted transaction missing from first stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_rem_below_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v[DIV_STAGES] |-> (d[DIV_STAGES].rem < d[DIV_STAGES].q))
        else $error("remainder not below modulus");
`endif

endmodule

// ===== tb/uniform_mod_q_rejection_sampler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_mod_q_rejection_sampler_checker
// Watches the config, input and output channels of the sampler. It keeps its
// own copy of the moduli, predicts the residue and accept flag of every input
// transaction, and compares each output transaction with the oldest one.
// ----------------------------------------------------------------------------
module uniform_mod_q_rejection_sampler_checker
    import urqs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [WORD_W-1:0]     i_s_tdata,
    input  logic [SEL_W-1:0]      i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tuser,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [OUT_DATA_W-1:0] residue;
        logic                  accepted;
    } t_sample;

    logic [MOD_W-1:0] moduli [MOD_COUNT];
    t_sample          sample_queue[$];
    int               fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = sample_queue.size();

    // Predict one sample: reject at or above the limit, else reduce mod q
    function automatic t_sample reduce_word(logic [WORD_W-1:0] word,
                                            logic [SEL_W-1:0] sel);
        t_sample          s;
        logic [WORD_W-1:0] q;
        logic [WORD_W-1:0] limit;
        s = '0;
        if (int'(sel) < MOD_COUNT) begin
            q = {3'b0, moduli[sel]};
            if (q == '0) q = 64'd1;
            limit = WORD_ONES - (WORD_ONES % q) - 64'd1;
            if (word < limit) begin
                s.residue  = word % q;
                s.accepted = 1'b1;
            end
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_sample got;
        t_sample want;
        if (!i_rst_n) begin
            for (int k = 0; k < MOD_COUNT; k++) moduli[k] <= MOD_RESET;
            sample_queue.delete();
            fail_count <= 0;
        end else begin
            // Track register writes
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < MOD_COUNT)
                moduli[i_cfg_index[SEL_W-1:0]] <= i_cfg_data[MOD_W-1:0];
            // Compare output transaction with oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got.residue  = i_m_tdata;
                got.accepted = i_m_tuser;
                if (sample_queue.size() == 0) begin
                    if (fail_count < 10) $display("unexpected output %h/%b",
                                                  got.residue, got.accepted);
                    fail_count <= fail_count + 1;
                end else begin
                    want = sample_queue.pop_front();
                    if (got != want) begin
                        if (fail_count < 10)
                            $display("mismatch: exp res %h acc %b, got res %h acc %b",
                                     want.residue, want.accepted,
                                     got.residue, got.accepted);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // Queue the prediction of an input transaction
            if (i_s_tvalid && i_s_tready)
                sample_queue.push_back(reduce_word(i_s_tdata, i_s_tuser));
        end
    end

endmodule

// ===== tb/uniform_mod_q_rejection_sampler_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_mod_q_rejection_sampler_top_test
// Drives directed and random words through the sampler over several modulus
// settings, with random gaps and output stalls, and reports the verdict.
// ----------------------------------------------------------------------------
module uniform_mod_q_rejection_sampler_top_test;
    import urqs_pkg::*;

    localparam int LATENCY = 34;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata = '0;
    logic [SEL_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;
    logic                  stall_enable = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    uniform_mod_q_rejection_sampler_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),   // random_word
        .i_s_axis_tuser(s_tuser),   // modulus_select
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),   // residue, zero pad
        .o_m_axis_tuser(m_tuser),   // accepted
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    uniform_mod_q_rejection_sampler_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Stall the output side at random, per transaction
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            gap = stall_enable ? $urandom_range(0, 7) : 0;
            if (gap != 0) begin
                @(negedge i_clk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic write_modulus(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic [WORD_W-1:0] w, input logic [SEL_W-1:0] sel,
                             input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        // tvalid stays high between back-to-back transactions
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= sel;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Pick a modulus: extremes, small, powers of two, random wide
    function automatic logic [CFG_DATA_W-1:0] pick_modulus();
        case ($urandom_range(0, 5))
            0: return 64'd2;
            1: return 64'h1FFF_FFFF_FFFF_FFFF;
            2: return CFG_DATA_W'($urandom_range(0, 20));
            3: return 64'd1 << $urandom_range(1, 60);
            4: return rand_word();
            default: return rand_word() & 64'h1FFF_FFFF_FFFF_FFFF;
        endcase
    endfunction

    initial begin
        logic [WORD_W-1:0] w;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset moduli, then extremes and special moduli
        send_word('0, SEL_W'(0), 1'b0);
        send_word(WORD_ONES, SEL_W'(1), 1'b0);
        send_word(WORD_ONES - 64'd1, SEL_W'(2), 1'b0);
        send_word(WORD_ONES - 64'd2, SEL_W'(3), 1'b0);
        drain();
        write_modulus(CFG_IDX_W'(0), 64'd0);
        write_modulus(CFG_IDX_W'(1), 64'd1);
        write_modulus(CFG_IDX_W'(2), 64'h1FFF_FFFF_FFFF_FFFF);
        write_modulus(CFG_IDX_W'(3), WORD_ONES);
        write_modulus(CFG_IDX_W'(4), 64'd7);
        write_modulus(8'hFF, 64'd9);
        for (int s = 0; s < MOD_COUNT; s++) begin
            send_word('0, SEL_W'(s), 1'b0);
            send_word(WORD_ONES, SEL_W'(s), 1'b0);
            send_word(WORD_ONES - 64'd1, SEL_W'(s), 1'b1);
            send_word(WORD_ONES - 64'd2, SEL_W'(s), 1'b1);
            send_word(64'h8000_0000_0000_0000, SEL_W'(s), 1'b0);
        end
        // Pause until every result is back
        drain();

        // Random phases with fresh moduli
        for (int phase = 0; phase < 7; phase++) begin
            for (int k = 0; k < MOD_COUNT; k++)
                write_modulus(CFG_IDX_W'(k), pick_modulus());
            if ($urandom_range(0, 3) == 0)
                write_modulus(CFG_IDX_W'($urandom_range(4, 255)), rand_word());
            stall_enable = (phase != 3);
            for (int n = 0; n < 100; n++) begin
                w = rand_word();
                // Push some words near the top, where rejection happens
                if ($urandom_range(0, 3) == 0)
                    w = WORD_ONES - WORD_W'($urandom_range(0, 1000));
                send_word(w, SEL_W'($urandom_range(0, 3)), phase == 3);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/urqs_pkg.sv
rtl/urqs_cfg_regs.sv
rtl/urqs_div_stage.sv
rtl/uniform_mod_q_rejection_sampler_top.sv
tb/uniform_mod_q_rejection_sampler_checker.sv
tb/uniform_mod_q_rejection_sampler_top_test.sv
